// ===== rtl/hsm_pkg.sv =====
// hsm_pkg: request and result types, operation codes and status codes
// shared by the header signature matcher unit; no dependencies
`default_nettype none

package hsm_pkg;

  // fixed field widths of the request and result
  localparam int OP_W     = 2;
  localparam int EI_W     = 10;
  localparam int BI_W     = 7;
  localparam int BYTE_W   = 8;
  localparam int OFF_W    = 8;
  localparam int LEN_W    = 8;
  localparam int EXT_W    = 16;
  localparam int THR_W    = 4;
  localparam int STAT_W   = 2;
  localparam int CFG_W    = 11;

  // operation codes
  localparam logic [OP_W-1:0] OP_PAT_WR = 2'd0;
  localparam logic [OP_W-1:0] OP_ENT_WR = 2'd1;
  localparam logic [OP_W-1:0] OP_HDR_WR = 2'd2;
  localparam logic [OP_W-1:0] OP_CHECK  = 2'd3;

  // extension status codes
  localparam logic [STAT_W-1:0] ST_EXT_MATCH = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISMATCH  = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_EXT    = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [EI_W-1:0]   entry_index;
    logic [BI_W-1:0]   byte_index;
    logic [BYTE_W-1:0] byte_value;
    logic [OFF_W-1:0]  pattern_offset;
    logic [LEN_W-1:0]  pattern_length;
    logic [EXT_W-1:0]  ext_code;
    logic [THR_W-1:0]  entry_threat;
    logic              ext_present;
  } hsm_req_t;

  typedef struct packed {
    logic              found;
    logic [EI_W-1:0]   match_index;
    logic [STAT_W-1:0] ext_status;
    logic [THR_W-1:0]  threat_out;
  } hsm_res_t;

  // one signature entry as held in the entry memory
  typedef struct packed {
    logic [OFF_W-1:0] off;
    logic [LEN_W-1:0] len;
    logic [EXT_W-1:0] ext;
    logic [THR_W-1:0] thr;
  } hsm_entry_t;

endpackage

`default_nettype wire

// ===== rtl/hsm_ram.sv =====
// hsm_ram: generic simple dual-port ram, one write port and one read port
// with registered read data; no dependencies
`default_nettype none

module hsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/header_signature_matcher_unit.sv =====
// Header signature matcher: load requests are taken while idle (busy stays low).
// A check walks entries 0..n-1: an entry state reads the fields of each entry, then
// a compare state checks pattern bytes up to the first mismatch (one byte pair a
// cycle from the pattern and header memories), then a closing state; the
// result strobe follows in the cycle after. The receiver cannot stall results.
// Reset empties the header at once through per-byte valid bits; no clearing pass.
`default_nettype none

module header_signature_matcher_unit
  import hsm_pkg::*;
#(
  parameter int ENTRIES       = 1024,
  parameter int PATTERN_BYTES = 128,
  parameter int HEADER_BYTES  = 128
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  hsm_req_t         req_i,
  output logic             result_valid_o,
  output hsm_res_t         rsp_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CFG_W-1:0] cfg_data_i
);

  localparam int EIW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW  = $clog2(ENTRIES + 1);
  localparam int PAW = (ENTRIES * PATTERN_BYTES > 1) ? $clog2(ENTRIES * PATTERN_BYTES) : 1;
  localparam int HAW = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
  localparam int EW  = $bits(hsm_entry_t);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ENTRY = 2'd1;
  localparam logic [1:0] S_CMP   = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]              state_q, state_d;
  logic [CW-1:0]           i_q, i_d, n_q, n_d, i_nxt;
  logic [PAW-1:0]          base_q, base_d;
  logic [LEN_W-1:0]        k_q, k_d;
  logic                    last_q, last_d;
  logic [OFF_W-1:0]        off_q, off_d;
  logic [LEN_W-1:0]        len_q, len_d;
  logic [EXT_W-1:0]        ext_q, ext_d;
  logic [THR_W-1:0]        thr_q, thr_d;
  logic                    found_q, found_d;
  logic [EI_W-1:0]         first_q, first_d;
  logic [THR_W-1:0]        fthr_q, fthr_d;
  logic                    extok_q, extok_d;
  logic [EXT_W-1:0]        chk_ext_q, chk_ext_d;
  logic                    chk_has_q, chk_has_d;
  logic [HEADER_BYTES-1:0] hvld_q, hvld_d;
  logic                    hv_rd_q;
  logic                    res_vld_q, res_vld_d;
  hsm_res_t                res_q, res_d;
  logic [CFG_W-1:0]        cfg_q;

  logic                    accept;
  logic                    pat_we, ent_we, hdr_we;
  logic [PAW-1:0]          pat_waddr, pat_raddr;
  logic [HAW-1:0]          hdr_raddr;
  logic [BYTE_W-1:0]       pat_rdata, hdr_rdata, hdr_byte;
  logic [EW-1:0]           ent_rdata;
  hsm_entry_t              ent, ent_wr;
  logic                    ent_ok;
  logic                    byte_eq;
  logic                    go_next;

  assign busy        = (state_q != S_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  // request decode for load operations
  assign pat_we = accept && (req_i.op == OP_PAT_WR)
                  && (int'(req_i.entry_index) < ENTRIES)
                  && (int'(req_i.byte_index) < PATTERN_BYTES);
  assign ent_we = accept && (req_i.op == OP_ENT_WR)
                  && (int'(req_i.entry_index) < ENTRIES);
  assign hdr_we = accept && (req_i.op == OP_HDR_WR)
                  && (int'(req_i.byte_index) < HEADER_BYTES);

  assign pat_waddr = PAW'(PAW'(req_i.entry_index) * PAW'(PATTERN_BYTES)
                          + PAW'(req_i.byte_index));

  assign ent_wr.off = req_i.pattern_offset;
  assign ent_wr.len = req_i.pattern_length;
  assign ent_wr.ext = req_i.ext_code;
  assign ent_wr.thr = req_i.entry_threat;

  // entry fields memory, read at the next entry index
  hsm_ram #(
    .WIDTH (EW),
    .DEPTH (ENTRIES)
  ) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (EIW'(req_i.entry_index)),
    .wdata_i (ent_wr),
    .raddr_i (i_d[EIW-1:0]),
    .rdata_o (ent_rdata)
  );

  assign ent = hsm_entry_t'(ent_rdata);

  // pattern byte memory, entry-major
  hsm_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (ENTRIES * PATTERN_BYTES)
  ) u_pat_ram (
    .clk_i   (clk_i),
    .we_i    (pat_we),
    .waddr_i (pat_waddr),
    .wdata_i (req_i.byte_value),
    .raddr_i (pat_raddr),
    .rdata_o (pat_rdata)
  );

  // header byte memory, bytes never written since the last check read as zero
  hsm_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (HEADER_BYTES)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (hdr_we),
    .waddr_i (HAW'(req_i.byte_index)),
    .wdata_i (req_i.byte_value),
    .raddr_i (hdr_raddr),
    .rdata_o (hdr_rdata)
  );

  // read addresses: first byte straight from the entry word, then from k
  always_comb begin
    if (state_q == S_ENTRY) begin
      pat_raddr = base_q;
      hdr_raddr = HAW'(ent.off);
    end else begin
      pat_raddr = PAW'(base_q + PAW'(k_q));
      hdr_raddr = HAW'({1'b0, off_q} + {1'b0, k_q});
    end
  end

  assign hdr_byte = hv_rd_q ? hdr_rdata : '0;
  assign byte_eq  = (hdr_byte == pat_rdata);
  assign ent_ok   = (ent.len != '0)
                    && (int'(ent.len) <= PATTERN_BYTES)
                    && (int'(ent.off) + int'(ent.len) <= HEADER_BYTES);
  assign i_nxt    = CW'(i_q + CW'(1));

  // check sequencer
  always_comb begin
    state_d   = state_q;
    i_d       = i_q;
    n_d       = n_q;
    base_d    = base_q;
    k_d       = k_q;
    last_d    = last_q;
    off_d     = off_q;
    len_d     = len_q;
    ext_d     = ext_q;
    thr_d     = thr_q;
    found_d   = found_q;
    first_d   = first_q;
    fthr_d    = fthr_q;
    extok_d   = extok_q;
    chk_ext_d = chk_ext_q;
    chk_has_d = chk_has_q;
    hvld_d    = hvld_q;
    res_vld_d = 1'b0;
    res_d     = res_q;
    go_next   = 1'b0;

    if (hdr_we) begin
      hvld_d[HAW'(req_i.byte_index)] = 1'b1;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept && (req_i.op == OP_CHECK)) begin
          i_d       = '0;
          base_d    = '0;
          found_d   = 1'b0;
          first_d   = '0;
          fthr_d    = '0;
          extok_d   = 1'b0;
          chk_ext_d = req_i.ext_code;
          chk_has_d = req_i.ext_present;
          n_d       = (int'(cfg_q) > ENTRIES) ? CW'(ENTRIES) : CW'(cfg_q);
          state_d   = (cfg_q == '0) ? S_DONE : S_ENTRY;
        end
      end
      S_ENTRY: begin
        off_d = ent.off;
        len_d = ent.len;
        ext_d = ent.ext;
        thr_d = ent.thr;
        if (ent_ok) begin
          // first byte pair is in flight, k points at the next one
          k_d     = LEN_W'(1);
          last_d  = (ent.len == LEN_W'(1));
          state_d = S_CMP;
        end else begin
          go_next = 1'b1;
        end
      end
      S_CMP: begin
        if (!byte_eq) begin
          go_next = 1'b1;
        end else if (last_q) begin
          // whole pattern equal: record the match
          go_next = 1'b1;
          if (!found_q) begin
            found_d = 1'b1;
            first_d = EI_W'(i_q);
            fthr_d  = thr_q;
          end
          if (ext_q == chk_ext_q) begin
            extok_d = 1'b1;
          end
        end else begin
          k_d    = LEN_W'(k_q + LEN_W'(1));
          last_d = (k_q == LEN_W'(len_q - LEN_W'(1)));
        end
      end
      S_DONE: begin
        res_vld_d         = 1'b1;
        res_d.found       = found_q;
        res_d.match_index = found_q ? first_q : '0;
        res_d.threat_out  = '0;
        priority if (!found_q) begin
          res_d.ext_status = ST_NOT_FOUND;
        end else if (!chk_has_q) begin
          res_d.ext_status = ST_NO_EXT;
        end else if (extok_q) begin
          res_d.ext_status = ST_EXT_MATCH;
        end else begin
          res_d.ext_status = ST_MISMATCH;
          res_d.threat_out = fthr_q;
        end
        hvld_d  = '0;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // advance to the next entry or close the check
    if (go_next) begin
      if (i_nxt == n_q) begin
        state_d = S_DONE;
      end else begin
        i_d     = i_nxt;
        base_d  = PAW'(base_q + PAW'(PATTERN_BYTES));
        state_d = S_ENTRY;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      hvld_q    <= '0;
      res_vld_q <= 1'b0;
      cfg_q     <= '0;
      i_q       <= '0;
    end else begin
      state_q   <= state_d;
      hvld_q    <= hvld_d;
      res_vld_q <= res_vld_d;
      i_q       <= i_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_q <= cfg_data_i;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    base_q    <= base_d;
    k_q       <= k_d;
    last_q    <= last_d;
    off_q     <= off_d;
    len_q     <= len_d;
    ext_q     <= ext_d;
    thr_q     <= thr_d;
    found_q   <= found_d;
    first_q   <= first_d;
    fthr_q    <= fthr_d;
    extok_q   <= extok_d;
    chk_ext_q <= chk_ext_d;
    chk_has_q <= chk_has_d;
    res_q     <= res_d;
    hv_rd_q   <= hvld_q[hdr_raddr];
  end

  assign result_valid_o = res_vld_q;
  assign rsp_o          = res_q;

`ifndef SYNTHESIS
  // a result appears only once the sequencer is back in idle
  a_res_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobe while busy");

  // one strobe per check
  a_res_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  // no match gives zero index and not-found status
  a_not_found : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !rsp_o.found) |->
      (rsp_o.match_index == '0) && (rsp_o.ext_status == ST_NOT_FOUND))
    else $error("inconsistent not-found result");

  // threat code only travels with a mismatch
  a_threat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (rsp_o.ext_status != ST_MISMATCH)) |->
      (rsp_o.threat_out == '0))
    else $error("threat code without mismatch");

  // an accepted check holds the unit busy
  a_check_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.op == OP_CHECK)) |=> busy)
    else $error("check request did not start the sequencer");
`endif

endmodule

`default_nettype wire
